>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and an active-low reset.
`define RRPT_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("rrpt: assertion failed");

// Same, on the block's own aclk / aresetn.
`define RRPT_ASSERT(label, prop) `RRPT_ASSERT_CLK(label, aclk, aresetn, prop)

`endif

>>> src/rrpt_pkg.sv
// Shared types and constants of the round-robin process table.
// No dependencies.
package rrpt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 16;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REMOVED   = 3'd1,
        STAT_COMPLETED = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INSERT = 4'b0010,
        ST_REMOVE = 4'b0100,
        ST_RUN    = 4'b1000
    } state_t;

    // table update request from the sequencer
    typedef struct packed {
        logic             append;
        logic             update;
        logic             drop;
        logic [IDX_W-1:0] idx;
    } tbl_op_t;

    // shared subtract / compare unit result
    typedef struct packed {
        logic [TIME_W-1:0] sat;      // a - b, floored at zero
        logic              sat_zero; // a <= b
        logic              eq;       // a == b
    } alu_res_t;

endpackage

>>> src/rrpt_alu.sv
// Shared 16-bit subtract / compare unit.
// Depends on rrpt_pkg.
module rrpt_alu (
    input  logic [rrpt_pkg::TIME_W-1:0] a,
    input  logic [rrpt_pkg::TIME_W-1:0] b,
    output rrpt_pkg::alu_res_t          res
);
    import rrpt_pkg::*;

    logic [TIME_W:0] diff;
    logic            borrow;
    logic            eq;

    assign diff   = {1'b0, a} - {1'b0, b};
    assign borrow = diff[TIME_W];
    assign eq     = (diff == '0);

    always_comb begin
        res.eq       = eq;
        res.sat_zero = borrow | eq;
        res.sat      = (borrow | eq) ? '0 : diff[TIME_W-1:0];
    end

endmodule

>>> src/rrpt_table.sv
// Process table: id / remaining-time registers, entry count, shift-down delete.
// Depends on rrpt_pkg.
module rrpt_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rrpt_pkg::tbl_op_t           op,
    input  logic [rrpt_pkg::ID_W-1:0]   wr_id,
    input  logic [rrpt_pkg::TIME_W-1:0] wr_time,
    input  logic [rrpt_pkg::IDX_W-1:0]  rd_idx,
    output logic [rrpt_pkg::ID_W-1:0]   rd_id,
    output logic [rrpt_pkg::TIME_W-1:0] rd_time,
    output logic [rrpt_pkg::CNT_W-1:0]  count
);
    import rrpt_pkg::*;

    logic [ID_W-1:0]   id_reg   [TABLE_SLOTS];
    logic [TIME_W-1:0] time_reg [TABLE_SLOTS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign rd_id   = id_reg[rd_idx];
    assign rd_time = time_reg[rd_idx];
    assign count   = count_reg;

    always_comb begin
        count_next = count_reg;
        if (op.append) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.drop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // entries: append at the tail, update in place, or close the gap on delete
    always_ff @(posedge aclk) begin
        if (op.append) begin
            id_reg[count_reg[IDX_W-1:0]]   <= wr_id;
            time_reg[count_reg[IDX_W-1:0]] <= wr_time;
        end
        if (op.update) begin
            time_reg[op.idx] <= wr_time;
        end
        if (op.drop) begin
            for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
                if (IDX_W'(j) >= op.idx) begin
                    id_reg[j]   <= id_reg[j+1];
                    time_reg[j] <= time_reg[j+1];
                end
            end
        end
    end

endmodule

>>> src/round_robin_process_table_unit.sv
// Round-robin process table. Holds up to 16 processes (id, remaining time)
// in insertion order. A word on the slave side carries an action in s_tuser:
// insert appends a process, remove deletes the oldest entry with the given id,
// run visits entries circularly, subtracting the configured slice per visit, and
// reports each process as completed when its time reaches zero, until the
// table is empty. Results leave one word at a time on the master side; the
// final result of an action has m_tlast set. The block handles one word at a
// time: s_tready is high only while the sequencer is idle. A remove scans
// entries from the oldest up to the matched position (or to the entry count
// when nothing matches); a run makes ceil(time / slice) visits per entry,
// an entry with zero time counting as one visit. Every visit or compare goes
// through the single shared subtract/compare unit. Output back-pressure
// stalls the sequencer while a new result waits behind a result word that
// is still held.
// Depends on rrpt_pkg, rrpt_alu, rrpt_table.
module round_robin_process_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] pid, [31:16] burst_time
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] result_id
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast,   // last result of this action
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rrpt_pkg::*;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   pid_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [TIME_W-1:0] slice_reg;
    logic [TIME_W-1:0] slice_eff;

    // output register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic              out_last_reg;
    logic              out_free;

    logic              emit;
    status_t           emit_status;
    logic [ID_W-1:0]   emit_id;
    logic              emit_last;

    tbl_op_t           op;
    logic [ID_W-1:0]   rd_id;
    logic [TIME_W-1:0] rd_time;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  cur_pos;
    logic [TIME_W-1:0] alu_a, alu_b;
    alu_res_t          alu_res;
    logic              table_full;
    logic              cfg_wr;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {16'd0, slice_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg <= TIME_W'(1);
        end else if (cfg_wr) begin
            slice_reg <= pwdata[TIME_W-1:0];
        end
    end

    // a zero slice behaves as one so that a run always terminates
    assign slice_eff = (slice_reg == '0) ? TIME_W'(1) : slice_reg;

    // ---------------- datapath ----------------
    // wrap the visit pointer back to the oldest entry once past the tail
    assign cur_pos    = (pos_reg >= count) ? '0 : pos_reg;
    assign table_full = (count == CNT_W'(TABLE_SLOTS));

    // run: remaining time minus slice; remove: stored id against request
    assign alu_a = (state_reg == ST_RUN) ? rd_time   : rd_id;
    assign alu_b = (state_reg == ST_RUN) ? slice_eff : pid_reg;

    rrpt_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    rrpt_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .wr_id   (pid_reg),
        .wr_time (op.append ? burst_reg : alu_res.sat),
        .rd_idx  (cur_pos[IDX_W-1:0]),
        .rd_id   (rd_id),
        .rd_time (rd_time),
        .count   (count)
    );

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = ~out_valid_reg | m_tready;

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        op          = '0;
        op.idx      = cur_pos[IDX_W-1:0];
        emit        = 1'b0;
        emit_status = STAT_INSERTED;
        emit_id     = pid_reg;
        emit_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                pos_next = '0;
                if (s_tvalid) begin
                    case (s_tuser)
                        ACT_INSERT: state_next = ST_INSERT;
                        ACT_REMOVE: state_next = ST_REMOVE;
                        ACT_RUN:    state_next = ST_RUN;
                        default:    state_next = ST_IDLE;  // no-op action
                    endcase
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = table_full ? STAT_FULL : STAT_INSERTED;
                    op.append   = ~table_full;
                    state_next  = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (pos_reg == count) begin
                    // scanned every entry without a match
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = STAT_NOT_FOUND;
                        state_next  = ST_IDLE;
                    end
                end else if (alu_res.eq) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = STAT_REMOVED;
                        op.drop     = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            ST_RUN: begin
                if (count == '0) begin
                    // only reachable when the run starts on an empty table
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = STAT_EMPTY;
                        emit_id     = '0;
                        state_next  = ST_IDLE;
                    end
                end else if (alu_res.sat_zero) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = STAT_COMPLETED;
                        emit_id     = rd_id;
                        emit_last   = (count == CNT_W'(1));
                        op.drop     = 1'b1;
                        pos_next    = cur_pos;  // next entry slides into this slot
                        if (count == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    op.update = 1'b1;
                    pos_next  = cur_pos + CNT_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // latch the accepted word
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pid_reg   <= s_tdata[ID_W-1:0];
            burst_reg <= s_tdata[ID_W +: TIME_W];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_status_reg <= emit_status;
            out_id_reg     <= emit_id;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> src/rrpt_checker.sv
// Port-level checks for round_robin_process_table_unit, bound to the top level.
// Depends on rrpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrpt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import rrpt_pkg::*;

    // a held result word keeps its payload
    `RRPT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a real action makes the block busy in the cycle after its acceptance
    `RRPT_ASSERT(a_busy_after_accept, s_tvalid && s_tready && (s_tuser == ACT_INSERT || s_tuser == ACT_REMOVE || s_tuser == ACT_RUN) |=> !s_tready)

    // empty-table status carries id zero and closes the action
    `RRPT_ASSERT(a_empty_word, m_tvalid && m_tuser == STAT_EMPTY |-> m_tlast && m_tdata == 16'd0)

    // every status but completed is a single-word answer
    `RRPT_ASSERT(a_single_last, m_tvalid && m_tuser != STAT_COMPLETED |-> m_tlast)

    // a completed word that is not last means the run continues: still busy
    `RRPT_ASSERT(a_run_busy, m_tvalid && m_tuser == STAT_COMPLETED && !m_tlast |-> !s_tready)

endmodule

bind round_robin_process_table_unit rrpt_checker u_rrpt_checker (.*);

>>> tb/tb.sv
// Testbench for round_robin_process_table_unit: directed and random stream traffic,
// with a built-in predictor of the table, checked word by word on the result stream.
// Depends on rrpt_pkg and the unit itself.
`timescale 1ns / 100ps

module tb;
    import rrpt_pkg::*;

    // Action code with no function in the block; it must produce no result word.
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    // Register map: the time slice is the only register.
    localparam logic [2:0] REG_SLICE      = 3'd0;
    // Quiet cycles allowed for an action that yields no result word.
    localparam int SETTLE_CYCLES = 20;

    // One table entry, as the predictor sees it.
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] left;
    } proc_entry_t;

    // One expected result word.
    typedef struct {
        status_t         status;
        logic [ID_W-1:0] id;
        logic            last;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [15:0] pid, [31:16] burst_time
    logic [1:0]  s_tuser;    // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] result_id
    logic [2:0]  m_tuser;    // [2:0] status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the process table in insertion order and the slice register.
    proc_entry_t       proc_table[$];
    logic [TIME_W-1:0] slice_model;

    // Results predicted but not yet seen on the master side, oldest first.
    sched_result_t pending_results[$];

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;

    round_robin_process_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic push_result(input status_t st, input logic [ID_W-1:0] id,
                               input logic lst);
        sched_result_t r;
        r.status = st;
        r.id     = id;
        r.last   = lst;
        pending_results.push_back(r);
    endtask

    // Predict the result words of one accepted input word and update the table.
    task automatic predict_action(input logic [1:0] act, input logic [ID_W-1:0] pid,
                                  input logic [TIME_W-1:0] burst);
        proc_entry_t       e;
        logic [TIME_W-1:0] slice;
        logic [ID_W-1:0]   done_id;
        int                pos;
        bit                found;
        case (act)
            ACT_INSERT: begin
                if (proc_table.size() >= TABLE_SLOTS) begin
                    push_result(STAT_FULL, pid, 1'b1);
                end else begin
                    e.id   = pid;
                    e.left = burst;
                    proc_table.push_back(e);
                    push_result(STAT_INSERTED, pid, 1'b1);
                end
            end
            ACT_REMOVE: begin
                // duplicates allowed: the oldest match goes
                found = 1'b0;
                for (int i = 0; i < proc_table.size() && !found; i++) begin
                    if (proc_table[i].id == pid) begin
                        proc_table.delete(i);
                        found = 1'b1;
                    end
                end
                push_result(found ? STAT_REMOVED : STAT_NOT_FOUND, pid, 1'b1);
            end
            ACT_RUN: begin
                // a zero slice behaves as one so the schedule always drains
                slice = (slice_model == '0) ? TIME_W'(1) : slice_model;
                if (proc_table.size() == 0) begin
                    push_result(STAT_EMPTY, '0, 1'b1);
                end else begin
                    pos = 0;
                    while (proc_table.size() > 0) begin
                        if (pos >= proc_table.size())
                            pos = 0;
                        if (proc_table[pos].left > slice)
                            proc_table[pos].left = proc_table[pos].left - slice;
                        else
                            proc_table[pos].left = '0;
                        if (proc_table[pos].left == '0) begin
                            done_id = proc_table[pos].id;
                            proc_table.delete(pos);
                            push_result(STAT_COMPLETED, done_id, proc_table.size() == 0);
                        end else begin
                            pos++;
                        end
                    end
                end
            end
            default: ;  // unused action: no effect, no result
        endcase
    endtask

    // Offer one word on the slave side; returns once it is accepted.
    // tvalid stays high after acceptance so back-to-back words need no toggle.
    task automatic send_action(input logic [1:0] act, input logic [ID_W-1:0] pid,
                               input logic [TIME_W-1:0] burst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {burst, pid};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        predict_action(act, pid, burst);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the slice register over APB while the block is idle, then read it back.
    task automatic program_slice(input logic [TIME_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SLICE;
        pwdata  <= {16'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        slice_model = value;
        // read-back: new setup phase straight after the write
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'b0, slice_model})
            report_mismatch($sformatf("slice read 0x%08h, wrote 0x%04h",
                                      prdata, slice_model));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        // narrow pool half the time so duplicates and remove hits are common
        if ($urandom_range(1))
            return ID_W'($urandom_range(7));
        return ID_W'($urandom_range(65535));
    endfunction

    function automatic logic [TIME_W-1:0] rand_burst();
        int s;
        // keep visits per process low: big bursts only with a big slice
        s = (slice_model == '0) ? 1 : int'(slice_model);
        if (s >= 4096)
            return TIME_W'($urandom_range(65535, 1));
        return TIME_W'($urandom_range(s * 8, 1));
    endfunction

    task automatic check_result();
        sched_result_t exp;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word status %0d id 0x%04h last %0b",
                                      m_tuser, m_tdata, m_tlast));
        end else begin
            exp = pending_results.pop_front();
            if (m_tuser !== exp.status)
                report_mismatch($sformatf("status %0d, expected %s (id 0x%04h)",
                                          m_tuser, exp.status.name(), exp.id));
            if (m_tdata !== exp.id)
                report_mismatch($sformatf("result_id 0x%04h, expected 0x%04h",
                                          m_tdata, exp.id));
            if (m_tlast !== exp.last)
                report_mismatch($sformatf("last %0b, expected %0b (id 0x%04h)",
                                          m_tlast, exp.last, exp.id));
        end
    endtask

    // Result side: check each accepted word, then pick tready for the next cycle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Empty table: run gives one table-empty word, remove misses,
    // unused action is silent.
    task automatic test_empty_table();
        send_action(ACT_RUN, 16'h0000, 16'h0001);
        send_action(ACT_REMOVE, 16'h1234, 16'h0001);
        send_action(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
    endtask

    // Id extremes, zero burst, duplicate ids with the oldest one removed.
    task automatic test_insert_remove();
        send_action(ACT_INSERT, 16'h0000, 16'h0001);
        send_action(ACT_INSERT, 16'hFFFF, 16'h0000);
        send_action(ACT_INSERT, 16'h5555, 16'h0003);
        send_action(ACT_INSERT, 16'hAAAA, 16'h0002);
        send_action(ACT_INSERT, 16'h5555, 16'h0001);
        send_action(ACT_REMOVE, 16'h5555, 16'h0001);
    endtask

    // Fill to capacity, overflow once, then drain it all with one run.
    task automatic test_full_table();
        while (proc_table.size() < TABLE_SLOTS)
            send_action(ACT_INSERT, rand_id(), TIME_W'($urandom_range(8, 1)));
        send_action(ACT_INSERT, 16'hBEEF, 16'h0004);
        send_action(ACT_RUN, 16'h0000, 16'h0001);
    endtask

    // Largest slice with the largest bursts, then a zero slice, then back to one.
    task automatic test_slice_extremes();
        program_slice(16'hFFFF);
        send_action(ACT_INSERT, rand_id(), 16'hFFFF);
        send_action(ACT_INSERT, rand_id(), 16'h8000);
        send_action(ACT_INSERT, rand_id(), 16'h7FFF);
        send_action(ACT_RUN, 16'h0000, 16'h0001);
        program_slice(16'h0000);
        send_action(ACT_INSERT, rand_id(), 16'h0003);
        send_action(ACT_INSERT, rand_id(), 16'h0001);
        send_action(ACT_RUN, 16'h0000, 16'h0001);
        program_slice(16'h0001);
    endtask

    // Mostly well-formed insert / remove / run traffic with random content,
    // with bursts of inserts that overflow the table and some noise.
    task automatic test_random_traffic(input int n_words);
        int sent;
        int r;
        int batch;
        logic [ID_W-1:0] pid;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_action(ACT_INSERT, rand_id(), rand_burst());
                sent++;
            end else if (r < 50) begin
                batch = $urandom_range(18, 4);
                repeat (batch) send_action(ACT_INSERT, rand_id(), rand_burst());
                sent += batch;
            end else if (r < 70) begin
                // usually hit a stored id, sometimes miss
                if (proc_table.size() > 0 && $urandom_range(9) < 7)
                    pid = proc_table[$urandom_range(proc_table.size() - 1)].id;
                else
                    pid = rand_id();
                send_action(ACT_REMOVE, pid, TIME_W'($urandom_range(65535)));
                sent++;
            end else if (r < 90) begin
                send_action(ACT_RUN, ID_W'($urandom_range(65535)),
                            TIME_W'($urandom_range(65535)));
                sent++;
            end else begin
                send_action(ACT_UNUSED, ID_W'($urandom_range(65535)),
                            TIME_W'($urandom_range(65535)));
            end
        end
    endtask

    // One idling mode, split over two random slice settings.
    task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_words);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (2) begin
            // empty the table first: old bursts never meet a much smaller slice
            send_action(ACT_RUN, 16'h0000, 16'h0001);
            case ($urandom_range(2))
                0:       program_slice(TIME_W'($urandom_range(16, 1)));
                1:       program_slice(TIME_W'($urandom_range(4095, 17)));
                default: program_slice(TIME_W'($urandom_range(65535, 4096)));
            endcase
            test_random_traffic(n_words / 2);
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= ACT_INSERT;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= REG_SLICE;
        pwdata         <= '0;
        slice_model    = 16'h0001;  // reset value of the register
        mismatch_count = 0;
        send_idle_pct  = 9;
        recv_idle_pct  = 52;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_insert_remove();
        test_full_table();
        test_slice_extremes();

        run_phase(9, 52, 130);
        run_phase(52, 9, 130);
        run_phase(0, 0, 130);

        // everything back, then a margin for any stray word
        drain_results();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rrpt_pkg.sv
src/rrpt_alu.sv
src/rrpt_table.sv
src/round_robin_process_table_unit.sv
src/rrpt_checker.sv
tb/tb.sv
